// ===== design/integer_alu_with_flags_macros.svh =====
// Assertion macros for the integer ALU checker
`ifndef INTEGER_ALU_WITH_FLAGS_MACROS_SVH
`define INTEGER_ALU_WITH_FLAGS_MACROS_SVH

`define IAF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define IAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/ialu_pkg.sv =====
package ialu_pkg;

  localparam int unsigned W = 32;
  localparam int unsigned CELLS = W;

  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,
    ACT_SUB  = 4'd1,
    ACT_CMP  = 4'd2,
    ACT_SHL  = 4'd3,
    ACT_SHR  = 4'd4,
    ACT_SAR  = 4'd5,
    ACT_MUL  = 4'd6,
    ACT_MULU = 4'd7,
    ACT_DIV  = 4'd8,
    ACT_DIVU = 4'd9,
    ACT_OR   = 4'd10,
    ACT_AND  = 4'd11,
    ACT_XOR  = 4'd12,
    ACT_NOT  = 4'd13
  } act_t;

  localparam logic [W-1:0] MSB32 = 32'h8000_0000;
  localparam logic [W-1:0] ALL32 = 32'hFFFF_FFFF;

  // one division cell's payload
  typedef struct packed {
    logic          valid;
    logic [3:0]    act;
    logic          neg_q;
    logic          neg_r;
    logic          special;
    logic [W-1:0]  divisor;
    logic [W-1:0]  rem;
    logic [W-1:0]  quo;
    logic [W-1:0]  res;
    logic [W-1:0]  hi;
    logic          wr;
    logic          wh;
    logic          ov;
    logic          cy;
    logic          fu;
    logic          dz;
  } cell_t;

endpackage

// ===== design/ialu_front.sv =====
module ialu_front
  import ialu_pkg::*;
(
  input  logic [3:0]   action,
  input  logic [W-1:0] operand_a,
  input  logic [W-1:0] operand_b,
  input  logic         carry_in,
  output cell_t        slot
);

  logic [4:0]   amt;
  logic [W:0]   sum;
  logic [W:0]   dif;
  logic [63:0]  wide;
  logic [W-1:0] ua;
  logic [W-1:0] ub;
  logic         nb;
  logic         na;

  assign amt = operand_a[4:0];
  assign sum = {1'b0, operand_b} + {1'b0, operand_a};
  assign dif = {1'b0, operand_b} - {1'b0, operand_a};
  assign nb  = operand_b[W-1];
  assign na  = operand_a[W-1];

  always_comb begin
    slot         = '0;
    slot.valid   = 1'b1;
    slot.act     = action;
    slot.wr      = 1'b1;
    slot.fu      = 1'b1;
    slot.cy      = carry_in;
    ua           = operand_a;
    ub           = operand_b;
    wide         = '0;
    case (action)
      ACT_ADD: begin
        slot.res = sum[W-1:0];
        slot.cy  = sum[W];
        slot.ov  = (operand_b[W-1] ~^ operand_a[W-1]) & (operand_b[W-1] ^ sum[W-1]);
      end
      ACT_SUB, ACT_CMP: begin
        slot.res = dif[W-1:0];
        slot.cy  = dif[W];
        slot.ov  = (operand_b[W-1] ^ operand_a[W-1]) & (operand_b[W-1] ^ dif[W-1]);
        slot.wr  = (action != ACT_CMP);
      end
      ACT_SHL: begin
        wide     = {32'd0, operand_b} << amt;
        slot.res = wide[W-1:0];
        slot.cy  = (amt != 5'd0) & wide[W];
      end
      ACT_SHR: begin
        wide     = {operand_b, 32'd0} >> amt;
        slot.res = wide[63:32];
        slot.cy  = (amt != 5'd0) & wide[31];
      end
      ACT_SAR: begin
        wide     = $signed({operand_b, 32'd0}) >>> amt;
        slot.res = wide[63:32];
        slot.cy  = (amt != 5'd0) & wide[31];
      end
      ACT_MUL, ACT_MULU: begin
        slot.wh = 1'b1;
      end
      ACT_DIV, ACT_DIVU: begin
        if (operand_a == '0) begin
          slot.wr = 1'b0;
          slot.fu = 1'b0;
          slot.dz = 1'b1;
          slot.cy = 1'b0;
          slot.special = 1'b1;
        end else begin
          slot.wh = 1'b1;
          if (action == ACT_DIV) begin
            if (operand_b == MSB32 && operand_a == ALL32) begin
              slot.special = 1'b1;
              slot.res     = MSB32;
              slot.ov      = 1'b1;
            end else begin
              ua         = na ? (W'(0) - operand_a) : operand_a;
              ub         = nb ? (W'(0) - operand_b) : operand_b;
              slot.neg_q = nb ^ na;
              slot.neg_r = nb;
            end
          end
        end
      end
      ACT_OR:  slot.res = operand_a | operand_b;
      ACT_AND: slot.res = operand_a & operand_b;
      ACT_XOR: slot.res = operand_a ^ operand_b;
      ACT_NOT: slot.res = ~operand_a;
      default: begin
        slot.wr = 1'b0;
        slot.fu = 1'b0;
        slot.cy = 1'b0;
      end
    endcase
    slot.divisor = ua;
    slot.quo     = ub;
    slot.rem     = '0;
  end

endmodule

// ===== design/ialu_div_cell.sv =====
module ialu_div_cell
  import ialu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t cell_in,
  output cell_t cell_out
);

  cell_t        cell_r;
  cell_t        cell_nxt;
  logic [W:0]   trial;
  logic [W:0]   shifted;

  // one restoring step: shift in next dividend bit, try subtract
  assign shifted = {cell_in.rem, cell_in.quo[W-1]};
  assign trial   = shifted - {1'b0, cell_in.divisor};

  always_comb begin
    cell_nxt = cell_in;
    if (trial[W]) begin
      cell_nxt.rem = shifted[W-1:0];
      cell_nxt.quo = {cell_in.quo[W-2:0], 1'b0};
    end else begin
      cell_nxt.rem = trial[W-1:0];
      cell_nxt.quo = {cell_in.quo[W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

// ===== design/ialu_mul.sv =====
module ialu_mul
  import ialu_pkg::*;
(
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] operand_a,
  input  logic [W-1:0] operand_b,
  output logic [63:0]  prod_u
);

  // 16x32 partial products, summed one stage later
  logic [47:0] pp_lo_r;
  logic [47:0] pp_hi_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo_r <= {16'd0, operand_b} * {32'd0, operand_a[15:0]};
      pp_hi_r <= {16'd0, operand_b} * {32'd0, operand_a[31:16]};
    end
  end

  assign prod_u = {16'd0, pp_lo_r} + {pp_hi_r, 16'd0};

endmodule

// ===== design/integer_alu_with_flags.sv =====
// Path: each accepted input word passes head_r, the divider cells and out_r in order.
// Throughput: one word per cycle while out_r is free; a 32-cell restoring divider
//   chain moves one stage per cycle and all actions flow through it in order.
// Stall: the whole chain advances only when the output register is free.
// Reset: rst_n synchronous active low clears all valid bits; no word is held.
module integer_alu_with_flags
  import ialu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[3:0], operand_a[35:4], operand_b[67:36], carry_in[68], zero fill
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result[31:0], high_word[63:32], writes_result[64], writes_high[65],
  // flag_zero[66], flag_sign[67], flag_overflow[68], flag_carry[69],
  // flags_update[70], divide_by_zero[71]
  output logic [71:0]  out_tdata
);

  logic          adv;
  cell_t         head;
  cell_t         head_r;
  cell_t         chain [CELLS+1];
  logic [63:0]   prod_u;
  logic [W-1:0]  sa_r;
  logic [W-1:0]  sb_r;
  logic          out_v_r;
  logic [71:0]   out_r;
  logic [71:0]   out_nxt;
  cell_t         t;
  logic [63:0]   prod;
  logic [W-1:0]  res;
  logic [W-1:0]  hi;
  logic          ov;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;

  ialu_front u_front (
    .action   (in_tdata[3:0]),
    .operand_a(in_tdata[35:4]),
    .operand_b(in_tdata[67:36]),
    .carry_in (in_tdata[68]),
    .slot     (head)
  );

  ialu_mul u_mul (
    .clk      (clk),
    .en       (adv),
    .operand_a(in_tdata[35:4]),
    .operand_b(in_tdata[67:36]),
    .prod_u   (prod_u)
  );

  // stage 0: capture word, finish multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else if (adv) begin
      head_r       <= head;
      head_r.valid <= in_tvalid;
      sa_r         <= in_tdata[35:4];
      sb_r         <= in_tdata[67:36];
    end
  end

  always_comb begin
    chain[0] = head_r;
    prod     = prod_u;
    if (head_r.act == ACT_MUL) begin
      prod[63:32] = prod_u[63:32] - (sa_r[W-1] ? sb_r : '0) - (sb_r[W-1] ? sa_r : '0);
    end
    if (head_r.act == ACT_MUL || head_r.act == ACT_MULU) begin
      chain[0].res = prod[31:0];
      chain[0].hi  = prod[63:32];
      chain[0].ov  = (head_r.act == ACT_MUL) ?
                     (prod[63:32] != {W{prod[31]}}) : (prod[63:32] != '0);
    end
  end

  genvar g;
  generate
    for (g = 0; g < CELLS; g++) begin : g_cell
      ialu_div_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .cell_in (chain[g]),
        .cell_out(chain[g+1])
      );
    end
  endgenerate

  always_comb begin
    t   = chain[CELLS];
    res = t.res;
    hi  = t.hi;
    ov  = t.ov;
    if ((t.act == ACT_DIV || t.act == ACT_DIVU) && !t.special) begin
      res = t.neg_q ? (W'(0) - t.quo) : t.quo;
      hi  = t.neg_r ? (W'(0) - t.rem) : t.rem;
    end
    out_nxt = {t.dz, t.fu, t.fu & t.cy, t.fu & ov, t.fu & res[W-1],
               t.fu & (res == '0), t.wh, t.wr, hi, res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= t.valid;
      out_r   <= out_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule

// ===== design/ialu_checker.sv =====
`include "integer_alu_with_flags_macros.svh"
module ialu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  `IAF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `IAF_ASSERT_IMPL(a_ready_free, !out_tvalid, in_tready)
  `IAF_ASSERT_IMPL(a_dz_noflags, out_tvalid && out_tdata[71], out_tdata[70:0] == 71'd0)
  `IAF_ASSERT_IMPL(a_noupd_clean, out_tvalid && !out_tdata[70], out_tdata[69:66] == 4'd0)

endmodule

bind integer_alu_with_flags ialu_checker u_ialu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
